// ----- src/ggs_pkg.sv -----
package ggs_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int COEF_W     = 32;
  localparam int SIZE_W     = 6;
  localparam int DIFF_W     = 37;
  localparam int HALO_TOTAL = 4;
  localparam int HALO_SIDE  = 2;
  localparam int NUM_BANKS  = 4;
  localparam int NUM_COPIES = 3;
  localparam int NUM_SLOTS  = 2 * NUM_COPIES;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_LATTICE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_X  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_Y  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_Z  = 3'd6;

  // read slots of every plane bank, relative to the current plane offset
  localparam int SLOT_CTR = 0;
  localparam int SLOT_YM2 = 1;
  localparam int SLOT_YM1 = 2;
  localparam int SLOT_YP1 = 3;
  localparam int SLOT_YP2 = 4;
  localparam int SLOT_ZP2 = 5;

  typedef struct packed {
    logic       emit;
    logic       last;
    logic [1:0] phase;
  } ggs_flags_t;

  function automatic logic signed [DIFF_W-1:0] ggs_sext(input logic signed [SAMPLE_W-1:0] v);
    return DIFF_W'(v);
  endfunction

endpackage

// ----- src/grid_gradient_stencil_3d_top.sv -----
// channel   direction  handshake              payload
// in        input      in_valid / in_stall    in_sample
// out       output     out_valid / out_stall  out_grad_x, out_grad_y, out_grad_z,
//                                             out_last_point
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one sample per cycle while not frozen; a result passes through the registered
// plane-store read, sign/magnitude, split multiply and saturated result registers
// the plane store is built from twelve two-read-port RAM copies so all taps read at once
// reset clears counters, valids and configuration registers only; the plane store needs no clearing pass
// out_stall with a result held freezes the whole pipeline and raises in_stall
module grid_gradient_stencil_3d_top #(
  parameter int MAX_DIM = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [ggs_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ggs_pkg::SAMPLE_W-1:0] out_grad_x,
  output logic signed [ggs_pkg::SAMPLE_W-1:0] out_grad_y,
  output logic signed [ggs_pkg::SAMPLE_W-1:0] out_grad_z,
  output logic                                out_last_point,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ggs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [31:0]                         cfg_data
);
  import ggs_pkg::*;

  localparam int SIDE  = MAX_DIM + HALO_TOTAL;
  localparam int PW    = $clog2(SIDE + 1);
  localparam int LW    = $clog2(SIDE * SIDE);
  localparam int DEPTH = 1 << LW;

  // configuration registers
  logic              lattice_r;
  logic [SIZE_W-1:0] size_x_r, size_y_r, size_z_r;
  logic [COEF_W-1:0] coef_x_r, coef_y_r, coef_z_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lattice_r <= 1'b0;
      size_x_r  <= SIZE_RESET;
      size_y_r  <= SIZE_RESET;
      size_z_r  <= SIZE_RESET;
      coef_x_r  <= '0;
      coef_y_r  <= '0;
      coef_z_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LATTICE: lattice_r <= cfg_data[0];
        CFG_SIZE_X:  size_x_r  <= cfg_data[SIZE_W-1:0];
        CFG_SIZE_Y:  size_y_r  <= cfg_data[SIZE_W-1:0];
        CFG_SIZE_Z:  size_z_r  <= cfg_data[SIZE_W-1:0];
        CFG_COEF_X:  coef_x_r  <= cfg_data;
        CFG_COEF_Y:  coef_y_r  <= cfg_data;
        CFG_COEF_Z:  coef_z_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline enable and request accept
  logic out_valid_r;
  logic en, accept;
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;
  assign accept   = in_valid && en;

  // position tracking
  ggs_flags_t    flags;
  logic [LW-1:0] lin;
  logic [PW-1:0] pz;

  ggs_pos #(.MAX_DIM(MAX_DIM)) u_pos (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv_i    (accept),
    .size_x_i (size_x_r),
    .size_y_i (size_y_r),
    .size_z_i (size_z_r),
    .flags_o  (flags),
    .lin_o    (lin),
    .pz_o     (pz)
  );

  // tap addresses inside a plane
  logic [LW-1:0] addr [NUM_SLOTS];
  always_comb begin
    addr[SLOT_CTR] = lin;
    addr[SLOT_YM2] = lin - (LW'(pz) << 1);
    addr[SLOT_YM1] = lin - LW'(pz);
    addr[SLOT_YP1] = lin + LW'(pz);
    addr[SLOT_YP2] = lin + (LW'(pz) << 1);
    addr[SLOT_ZP2] = lin + LW'(2);
  end

  // plane store: one bank per plane modulo four, copies for read bandwidth
  logic [NUM_BANKS-1:0] wr_en;
  logic [SAMPLE_W-1:0]  rd [NUM_BANKS][NUM_SLOTS];

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    assign wr_en[b] = accept && (flags.phase == 2'(b));
    for (genvar c = 0; c < NUM_COPIES; c++) begin : g_copy
      ggs_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_ram (
        .clk       (clk),
        .we_i      (wr_en[b]),
        .waddr_i   (lin),
        .wdata_i   (in_sample),
        .re_i      (accept),
        .raddr_a_i (addr[2*c]),
        .raddr_b_i (addr[2*c+1]),
        .rdata_a_o (rd[b][2*c]),
        .rdata_b_o (rd[b][2*c+1])
      );
    end
  end

  // stage 1: request with its store reads
  logic                       s1_v_r, s1_emit_r, s1_last_r;
  logic [1:0]                 s1_ph_r;
  logic signed [SAMPLE_W-1:0] s1_cur_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_emit_r <= flags.emit;
      s1_last_r <= flags.last;
      s1_ph_r   <= flags.phase;
      s1_cur_r  <= in_sample;
    end
  end

  // bank of each plane behind the current one
  logic [1:0] bk1, bk2, bk3;
  assign bk1 = s1_ph_r - 2'd1;
  assign bk2 = s1_ph_r - 2'd2;
  assign bk3 = s1_ph_r - 2'd3;

  // z window over the centre row, fed by the read two ahead
  logic signed [SAMPLE_W-1:0] zw_r [4];
  logic signed [SAMPLE_W-1:0] z_ahead;
  assign z_ahead = rd[bk2][SLOT_ZP2];

  always_ff @(posedge clk) begin
    if (en && s1_v_r) begin
      zw_r[0] <= z_ahead;
      zw_r[1] <= zw_r[0];
      zw_r[2] <= zw_r[1];
      zw_r[3] <= zw_r[2];
    end
  end

  // difference sums per axis
  logic signed [DIFF_W-1:0] dx, dy, dz, dy_orth, dy_hex;
  always_comb begin
    dx = (ggs_sext(rd[s1_ph_r][SLOT_CTR]) - ggs_sext(s1_cur_r)) +
         ((ggs_sext(rd[bk1][SLOT_CTR]) - ggs_sext(rd[bk3][SLOT_CTR])) <<< 3);
    dy_orth = (ggs_sext(rd[bk2][SLOT_YM2]) - ggs_sext(rd[bk2][SLOT_YP2])) +
              ((ggs_sext(rd[bk2][SLOT_YP1]) - ggs_sext(rd[bk2][SLOT_YM1])) <<< 3);
    dy_hex = (ggs_sext(rd[bk1][SLOT_YM2]) - ggs_sext(rd[bk3][SLOT_YP2])) +
             (((ggs_sext(rd[bk2][SLOT_YP1]) + ggs_sext(rd[bk3][SLOT_YP1])) -
               (ggs_sext(rd[bk1][SLOT_YM1]) + ggs_sext(rd[bk2][SLOT_YM1]))) <<< 2);
    dy = lattice_r ? dy_hex : dy_orth;
    dz = (ggs_sext(zw_r[3]) - ggs_sext(z_ahead)) +
         ((ggs_sext(zw_r[0]) - ggs_sext(zw_r[2])) <<< 3);
  end

  // stages 2 and 3: scaling units
  logic [SAMPLE_W-1:0] res_x, res_y, res_z;

  ggs_scale u_scale_x (.clk(clk), .en_i(en), .coef_i(coef_x_r), .diff_i(dx), .res_o(res_x));
  ggs_scale u_scale_y (.clk(clk), .en_i(en), .coef_i(coef_y_r), .diff_i(dy), .res_o(res_y));
  ggs_scale u_scale_z (.clk(clk), .en_i(en), .coef_i(coef_z_r), .diff_i(dz), .res_o(res_z));

  logic s2_v_r, s3_v_r, s2_last_r, s3_last_r;
  logic out_last_r;
  logic [SAMPLE_W-1:0] out_gx_r, out_gy_r, out_gz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s2_v_r      <= s1_v_r && s1_emit_r;
      s3_v_r      <= s2_v_r;
      out_valid_r <= s3_v_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (en) begin
      s2_last_r  <= s1_last_r;
      s3_last_r  <= s2_last_r;
      out_last_r <= s3_last_r;
      out_gx_r   <= res_x;
      out_gy_r   <= res_y;
      out_gz_r   <= res_z;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_grad_x     = signed'(out_gx_r);
  assign out_grad_y     = signed'(out_gy_r);
  assign out_grad_z     = signed'(out_gz_r);
  assign out_last_point = out_last_r;

  // checks
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall))
    else $error("input stalled without a held result");

  a_one_bank_written: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(wr_en))
    else $error("more than one plane bank written");

  a_result_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s3_v_r))
    else $error("result appeared without an emitting request");

  a_no_write_when_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    !en |-> (wr_en == '0))
    else $error("plane store written while the pipeline is frozen");

endmodule

// ----- src/ggs_ram.sv -----
module ggs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  // one write port, two registered read ports, old data on collision
  always_ff @(posedge clk) begin
    if (we_i) begin
      mem_r[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_r <= mem_r[raddr_a_i];
      rdata_b_r <= mem_r[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_r;
  assign rdata_b_o = rdata_b_r;

endmodule

// ----- src/ggs_pos.sv -----
module ggs_pos #(
  parameter int MAX_DIM = 32,
  localparam int SIDE = MAX_DIM + ggs_pkg::HALO_TOTAL,
  localparam int PW = $clog2(SIDE + 1),
  localparam int LW = $clog2(SIDE * SIDE)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv_i,
  input  logic [ggs_pkg::SIZE_W-1:0]  size_x_i,
  input  logic [ggs_pkg::SIZE_W-1:0]  size_y_i,
  input  logic [ggs_pkg::SIZE_W-1:0]  size_z_i,
  output ggs_pkg::ggs_flags_t         flags_o,
  output logic [LW-1:0]               lin_o,
  output logic [PW-1:0]               pz_o
);
  import ggs_pkg::*;

  logic [PW-1:0] pos_x_r, pos_x_nxt;
  logic [PW-1:0] pos_y_r, pos_y_nxt;
  logic [PW-1:0] pos_z_r, pos_z_nxt;
  logic [LW-1:0] lin_r, lin_nxt;
  logic [PW-1:0] px, py, pz;
  logic          z_end, y_end, x_end;
  logic          in_x, in_y, in_z;

  function automatic logic [PW-1:0] eff_size(input logic [SIZE_W-1:0] s);
    logic [PW-1:0] e;
    if (s == '0) begin
      e = PW'(1);
    end else if (32'(s) > 32'(MAX_DIM)) begin
      e = PW'(MAX_DIM);
    end else begin
      e = PW'(s);
    end
    return e;
  endfunction

  // padded extents
  assign px = eff_size(size_x_i) + PW'(HALO_TOTAL);
  assign py = eff_size(size_y_i) + PW'(HALO_TOTAL);
  assign pz = eff_size(size_z_i) + PW'(HALO_TOTAL);

  // interior window of the point two planes back
  assign in_x = (pos_x_r >= PW'(HALO_TOTAL)) && (pos_x_r < px);
  assign in_y = (pos_y_r >= PW'(HALO_SIDE)) &&
                ((PW+1)'(pos_y_r) + (PW+1)'(3) <= (PW+1)'(py));
  assign in_z = (pos_z_r >= PW'(HALO_SIDE)) &&
                ((PW+1)'(pos_z_r) + (PW+1)'(3) <= (PW+1)'(pz));

  assign flags_o.emit  = in_x && in_y && in_z;
  assign flags_o.last  = (pos_x_r == px - PW'(1)) && (pos_y_r == py - PW'(3)) &&
                         (pos_z_r == pz - PW'(3));
  assign flags_o.phase = pos_x_r[1:0];
  assign lin_o = lin_r;
  assign pz_o  = pz;

  // raster advance, z fastest
  assign z_end = (PW+1)'(pos_z_r) + (PW+1)'(1) >= (PW+1)'(pz);
  assign y_end = (PW+1)'(pos_y_r) + (PW+1)'(1) >= (PW+1)'(py);
  assign x_end = (PW+1)'(pos_x_r) + (PW+1)'(1) >= (PW+1)'(px);

  always_comb begin
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    pos_z_nxt = pos_z_r + PW'(1);
    lin_nxt   = lin_r + LW'(1);
    if (z_end) begin
      pos_z_nxt = '0;
      if (y_end) begin
        pos_y_nxt = '0;
        lin_nxt   = '0;
        pos_x_nxt = x_end ? '0 : pos_x_r + PW'(1);
      end else begin
        pos_y_nxt = pos_y_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
      pos_z_r <= '0;
      lin_r   <= '0;
    end else if (adv_i) begin
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
      pos_z_r <= pos_z_nxt;
      lin_r   <= lin_nxt;
    end
  end

endmodule

// ----- src/ggs_scale.sv -----
module ggs_scale (
  input  logic                               clk,
  input  logic                               en_i,
  input  logic [ggs_pkg::COEF_W-1:0]         coef_i,
  input  logic signed [ggs_pkg::DIFF_W-1:0]  diff_i,
  output logic [ggs_pkg::SAMPLE_W-1:0]       res_o
);
  import ggs_pkg::*;

  localparam int HI_W  = DIFF_W - 32;
  localparam int PHI_W = HI_W + COEF_W;
  localparam int RND_W = 64 - 24;
  localparam int MW    = PHI_W + 9;
  localparam logic [63:0] ROUND_HALF = 64'h0000_0000_0080_0000;

  logic              neg_a_r;
  logic [DIFF_W-1:0] mag_a_r;
  logic              neg_b_r;
  logic [PHI_W-1:0]  phi_r;
  logic [63:0]       plo_r;
  logic [63:0]       rnd_sum;
  logic [RND_W-1:0]  rnd;
  logic [MW-1:0]     mag;

  // magnitude and sign, then split product over the high and low words
  always_ff @(posedge clk) begin
    if (en_i) begin
      neg_a_r <= diff_i[DIFF_W-1];
      mag_a_r <= diff_i[DIFF_W-1] ? DIFF_W'(-diff_i) : DIFF_W'(diff_i);
      neg_b_r <= neg_a_r;
      phi_r   <= PHI_W'(mag_a_r[DIFF_W-1:32]) * PHI_W'(coef_i);
      plo_r   <= 64'(mag_a_r[31:0]) * 64'(coef_i);
    end
  end

  // round half away from zero on the magnitude, then saturate
  assign rnd_sum = plo_r + ROUND_HALF;
  assign rnd     = rnd_sum[63:24];
  assign mag     = MW'({phi_r, 8'b0}) + MW'(rnd);

  always_comb begin
    if (neg_b_r) begin
      res_o = (|mag[MW-1:31]) ? 32'h8000_0000 : 32'd0 - mag[31:0];
    end else begin
      res_o = (|mag[MW-1:31]) ? 32'h7FFF_FFFF : mag[31:0];
    end
  end

endmodule

// ----- tb/ggs_gradient_checker.sv -----
module ggs_gradient_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic signed [ggs_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [ggs_pkg::SAMPLE_W-1:0] out_grad_x,
  input  logic signed [ggs_pkg::SAMPLE_W-1:0] out_grad_y,
  input  logic signed [ggs_pkg::SAMPLE_W-1:0] out_grad_z,
  input  logic                                out_last_point,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [ggs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [31:0]                         cfg_data,
  output int                                  fail_count,
  output int                                  grads_pending
);
  import ggs_pkg::*;

  localparam int MAX_SIDE = 32;
  localparam int SIDE     = MAX_SIDE + HALO_TOTAL;

  typedef struct {
    logic signed [SAMPLE_W-1:0] gx;
    logic signed [SAMPLE_W-1:0] gy;
    logic signed [SAMPLE_W-1:0] gz;
    logic                       last;
  } grad_t;

  grad_t grad_expected[$];

  // shadow of the four padded planes and the raster position
  logic signed [SAMPLE_W-1:0] plane_mem [NUM_BANKS][SIDE][SIDE];
  int unsigned pos_x, pos_y, pos_z;

  // shadow configuration
  logic              hex_mode;
  logic [SIZE_W-1:0] dim_x, dim_y, dim_z;
  logic [COEF_W-1:0] k_x, k_y, k_z;

  assign grads_pending = grad_expected.size();

  function automatic int unsigned eff_dim(input logic [SIZE_W-1:0] s);
    if (s == 0) return 1;
    if (s > MAX_SIDE) return MAX_SIDE;
    return 32'(s);
  endfunction

  function automatic longint tap(input int unsigned p, input int unsigned y,
                                 input int unsigned z);
    return longint'(plane_mem[p % NUM_BANKS][y % SIDE][z % SIDE]);
  endfunction

  // q16.16 difference times unsigned q8.24, round half away, saturate
  function automatic logic signed [SAMPLE_W-1:0] scale_q16(input longint d,
                                                            input logic [COEF_W-1:0] t2);
    longint unsigned m, hi, lo, mag;
    m   = (d < 0) ? longint'(-d) : longint'(d);
    hi  = m >> 32;
    lo  = m & 64'hFFFF_FFFF;
    mag = hi * t2 * 256 + ((lo * t2 + (64'd1 << 23)) >> 24);
    if (d < 0) begin
      if (mag >= 64'h8000_0000) return 32'sh8000_0000;
      return -$signed(mag[31:0]);
    end
    if (mag > 64'h7FFF_FFFF) return 32'sh7FFF_FFFF;
    return mag[31:0];
  endfunction

  function automatic void predict_gradient(input logic signed [SAMPLE_W-1:0] cur_s);
    int unsigned px, py, pz, xx, yy, zz, c;
    longint cur, dx, dy, dz, a, e, p, q;
    grad_t g;
    px  = eff_dim(dim_x) + HALO_TOTAL;
    py  = eff_dim(dim_y) + HALO_TOTAL;
    pz  = eff_dim(dim_z) + HALO_TOTAL;
    xx  = pos_x;
    yy  = pos_y;
    zz  = pos_z;
    cur = longint'(cur_s);
    if (xx >= 4 && xx < px && yy >= 2 && yy + 3 <= py && zz >= 2 && zz + 3 <= pz) begin
      c  = xx - 2;
      dx = (tap(xx - 4, yy, zz) - cur) + 8 * (tap(xx - 1, yy, zz) - tap(xx - 3, yy, zz));
      if (hex_mode) begin
        a  = tap(c + 1, yy - 2, zz);
        e  = tap(c - 1, yy + 2, zz);
        p  = tap(c + 1, yy - 1, zz) + tap(c, yy - 1, zz);
        q  = tap(c, yy + 1, zz) + tap(c - 1, yy + 1, zz);
        dy = (a - e) + 4 * (q - p);
      end else begin
        dy = (tap(c, yy - 2, zz) - tap(c, yy + 2, zz)) +
             8 * (tap(c, yy + 1, zz) - tap(c, yy - 1, zz));
      end
      dz = (tap(c, yy, zz - 2) - tap(c, yy, zz + 2)) +
           8 * (tap(c, yy, zz + 1) - tap(c, yy, zz - 1));
      g.gx   = scale_q16(dx, k_x);
      g.gy   = scale_q16(dy, k_y);
      g.gz   = scale_q16(dz, k_z);
      g.last = (xx == px - 1 && yy == py - 3 && zz == pz - 3);
      grad_expected.push_back(g);
    end
    plane_mem[xx % NUM_BANKS][yy % SIDE][zz % SIDE] = cur_s;
    // raster advance, z fastest
    if (zz + 1 >= pz) begin
      pos_z = 0;
      if (yy + 1 >= py) begin
        pos_y = 0;
        pos_x = (xx + 1 >= px) ? 0 : xx + 1;
      end else begin
        pos_y = yy + 1;
      end
    end else begin
      pos_z = zz + 1;
    end
  endfunction

  always @(posedge clk) begin
    grad_t g;
    if (!rst_n) begin
      grad_expected.delete();
      pos_x      = 0;
      pos_y      = 0;
      pos_z      = 0;
      hex_mode   = 1'b0;
      dim_x      = SIZE_RESET;
      dim_y      = SIZE_RESET;
      dim_z      = SIZE_RESET;
      k_x        = '0;
      k_y        = '0;
      k_z        = '0;
      fail_count = 0;
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LATTICE: hex_mode = cfg_data[0];
          CFG_SIZE_X:  dim_x = cfg_data[SIZE_W-1:0];
          CFG_SIZE_Y:  dim_y = cfg_data[SIZE_W-1:0];
          CFG_SIZE_Z:  dim_z = cfg_data[SIZE_W-1:0];
          CFG_COEF_X:  k_x = cfg_data;
          CFG_COEF_Y:  k_y = cfg_data;
          CFG_COEF_Z:  k_z = cfg_data;
          default: ;
        endcase
      end
      // compare accepted results first, then predict from the new sample
      if (out_valid && !out_stall) begin
        if (grad_expected.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected gradient x=%h y=%h z=%h last=%b",
                     out_grad_x, out_grad_y, out_grad_z, out_last_point);
          fail_count++;
        end else begin
          g = grad_expected.pop_front();
          if (g.gx !== out_grad_x || g.gy !== out_grad_y || g.gz !== out_grad_z ||
              g.last !== out_last_point) begin
            if (fail_count < 10)
              $display("gradient mismatch exp x=%h y=%h z=%h last=%b got x=%h y=%h z=%h last=%b",
                       g.gx, g.gy, g.gz, g.last,
                       out_grad_x, out_grad_y, out_grad_z, out_last_point);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) predict_gradient(in_sample);
    end
  end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  import ggs_pkg::*;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [SAMPLE_W-1:0] out_grad_x, out_grad_y, out_grad_z;
  logic                       out_last_point;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [31:0]                cfg_data;
  int                         fail_count;
  int                         grads_pending;

  // idle pattern: 0 receiver busy-ish, 1 sender busy-ish, 2 none
  int idle_phase;
  int samples_sent;

  grid_gradient_stencil_3d_top u_top (.*);

  ggs_gradient_checker u_checker (.*);

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  initial begin
    #3000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // receiver stall, with one long hold-off to back the block up
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held      = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!held && idle_phase == 2 && samples_sent > 650) begin
        held      = 1;
        hold_left = 300;
        out_stall <= 1'b1;
      end else begin
        case (idle_phase)
          0: out_stall <= ($urandom_range(99) < 54);
          1: out_stall <= ($urandom_range(99) < 22);
          default: out_stall <= 1'b0;
        endcase
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // valid stays up after an accept so requests can follow back to back
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] v);
    int gap;
    idle_phase = (samples_sent < 300) ? 0 : (samples_sent < 530) ? 1 : 2;
    gap = (idle_phase == 0) ? 22 : (idle_phase == 1) ? 54 : 0;
    while ($urandom_range(99) < gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= v;
    samples_sent++;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(5))
      0: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1, 2: return $urandom_range(2000000) - 1000000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_coef();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h0015_5555;
      default: return $urandom;
    endcase
  endfunction

  // settle after the last result, then program the lattice, a new grid shape and the coefficients
  task automatic set_grid(input logic hex, input logic [5:0] sx, input logic [5:0] sy,
                          input logic [5:0] sz, input logic [31:0] cx,
                          input logic [31:0] cy, input logic [31:0] cz);
    while (grads_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    write_reg(CFG_LATTICE, {31'd0, hex});
    write_reg(CFG_SIZE_X, {26'd0, sx});
    write_reg(CFG_SIZE_Y, {26'd0, sy});
    write_reg(CFG_SIZE_Z, {26'd0, sz});
    write_reg(CFG_COEF_X, cx);
    write_reg(CFG_COEF_Y, cy);
    write_reg(CFG_COEF_Z, cz);
  endtask

  function automatic int padded(input logic [5:0] s);
    if (s == 0) return 1 + HALO_TOTAL;
    if (s > 32) return 32 + HALO_TOTAL;
    return s + HALO_TOTAL;
  endfunction

  task automatic run_grid(input logic [5:0] sx, input logic [5:0] sy, input logic [5:0] sz,
                          input bit alternating);
    int n;
    n = padded(sx) * padded(sy) * padded(sz);
    for (int i = 0; i < n; i++) begin
      if (alternating) send_sample(i[0] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
      else send_sample(pick_sample());
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    logic [5:0] sx, sy, sz;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_sample    = '0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_LATTICE;
    cfg_data     = '0;
    idle_phase   = 0;
    samples_sent = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: saturating swings in both lattices, zero dims
    set_grid(1'b0, 6'd1, 6'd1, 6'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_grid(6'd1, 6'd1, 6'd1, 1'b1);
    set_grid(1'b1, 6'd1, 6'd2, 6'd1, 32'h0100_0000, 32'hFFFF_FFFF, 32'h0);
    run_grid(6'd1, 6'd2, 6'd1, 1'b1);
    set_grid(1'b1, 6'd0, 6'd1, 6'd0, 32'h0015_5555, 32'h0012_7A2B, 32'h0015_5555);
    run_grid(6'd0, 6'd1, 6'd0, 1'b0);

    // random grids, mostly small
    while (samples_sent < 760) begin
      sx = 6'($urandom_range(1, 3));
      sy = 6'($urandom_range(1, 3));
      sz = 6'($urandom_range(1, 4));
      if ($urandom_range(9) == 0) sz = 6'd0;
      set_grid($urandom_range(1), sx, sy, sz, pick_coef(), pick_coef(), pick_coef());
      run_grid(sx, sy, sz, 1'b0);
    end

    while (grads_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- sim.f -----
src/ggs_pkg.sv
src/ggs_ram.sv
src/ggs_pos.sv
src/ggs_scale.sv
src/grid_gradient_stencil_3d_top.sv
tb/ggs_gradient_checker.sv
tb/tb_top.sv
